>>> hdl/lin_slave_frame_handler_core_macros.svh
// Assertion macros used by the LIN slave frame handler RTL.
`ifndef LIN_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH
`define LIN_SLAVE_FRAME_HANDLER_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define LSFH_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lsfh invariant violated");

// Consequent holds in the cycle after the antecedent.
`define LSFH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsfh sequence violated");

`endif

>>> hdl/lsfh_pkg.sv
// Types and codes of the LIN slave frame handler.
`default_nettype none

package lsfh_pkg;

    // Input commands
    localparam logic [1:0] CMD_BREAK   = 2'd0;
    localparam logic [1:0] CMD_RX_BYTE = 2'd1;
    localparam logic [1:0] CMD_TX_BYTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENTRY_COUNT     = 2'd0;
    localparam logic [1:0] CFG_FRAME_TABLE     = 2'd1;
    localparam logic [1:0] CFG_PARITY_ENABLE   = 2'd2;
    localparam logic [1:0] CFG_CHECKSUM_ENABLE = 2'd3;

    localparam int unsigned CFG_DATA_W = 56;
    localparam int unsigned ENTRY_W    = 7;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

    typedef enum logic [3:0] {
        EV_SYNC_ERROR    = 4'd0,
        EV_PARITY_ERROR  = 4'd1,
        EV_UNKNOWN_ID    = 4'd2,
        EV_RECEIVE_START = 4'd3,
        EV_RESPOND_REQ   = 4'd4,
        EV_DATA_BYTE     = 4'd5,
        EV_FRAME_OK      = 4'd6,
        EV_CHECKSUM_ERR  = 4'd7,
        EV_TX_BYTE       = 4'd8,
        EV_TX_CHECKSUM   = 4'd9
    } event_t;

    // Declared high to low so event_res lands in the lowest bits.
    typedef struct packed {
        logic [3:0] byte_position;
        logic [7:0] byte_out;
        logic [3:0] frame_length;
        logic [2:0] table_index;
        logic [5:0] frame_id;
        event_t     event_res;
    } result_t;

    typedef struct packed {
        logic    last;
        result_t res;
    } queue_entry_t;

endpackage

`default_nettype wire

>>> hdl/lin_slave_frame_handler_core.sv
// LIN slave frame handler: break/sync/identifier decode, ID table match, data and checksum.
//
// Takes one request per clock while the output queue has room: a request is registered,
// decoded in a single pass against the frame state and the ID table (all entries compared
// in parallel), and its zero, one or two results are written into a four-entry output
// queue that drains one result per clock while the sink is ready. A request that yields
// one result passes at one per clock while the sink keeps up; a request that yields two
// results (last receive byte with checksum off, every transmit byte of a transmit frame)
// fills two queue entries. Input stalls only while the queue holds more than two results.
// A request passes the input register and then the output queue on its way to the output.
`default_nettype none

module lin_slave_frame_handler_core #(
    parameter int unsigned TABLE_ENTRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [lsfh_pkg::CFG_DATA_W-1:0] cfg_data,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [5:0] frame_id, [8:6] table_index,
                                        // [12:9] frame_length, [20:13] byte_out,
                                        // [24:21] byte_position, [31:25] zero
    output logic [3:0]       m_tuser,   // [3:0] event_res
    output logic             m_tlast
);

`include "lin_slave_frame_handler_core_macros.svh"

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_IDENT,
        PH_RXDATA,
        PH_RXCK,
        PH_TXDATA
    } phase_t;

    // Configuration
    logic [3:0]                         entry_count_reg;
    logic [lsfh_pkg::ENTRY_W-1:0]       table_reg [TABLE_ENTRIES];
    logic                               parity_enable_reg;
    logic                               checksum_enable_reg;

    // Input register
    logic                               in_valid_reg;
    logic [1:0]                         in_cmd_reg;
    logic [7:0]                         in_byte_reg;

    // Frame state
    phase_t                             phase_reg, phase_next;
    logic [5:0]                         current_id_reg, current_id_next;
    logic [2:0]                         matched_index_reg, matched_index_next;
    logic [3:0]                         expected_length_reg, expected_length_next;
    logic [3:0]                         byte_count_reg, byte_count_next;
    logic [7:0]                         checksum_sum_reg, checksum_sum_next;

    // Output queue
    lsfh_pkg::queue_entry_t             queue_mem [QUEUE_DEPTH];
    logic [1:0]                         wr_ptr_reg, rd_ptr_reg;
    logic [2:0]                         count_reg;
    lsfh_pkg::queue_entry_t             head;

    logic                               fire;
    logic                               pop;
    logic [1:0]                         n_res;
    lsfh_pkg::result_t                  res0, res1;

    // Decode helpers
    logic [5:0]                         id_in;
    logic [1:0]                         parity_calc;
    logic                               hit;
    logic [2:0]                         hit_idx;
    logic                               hit_rx;
    logic [3:0]                         len_sel;
    logic [8:0]                         sum_wide;
    logic [7:0]                         sum_new;
    logic [3:0]                         count_inc;

    assign fire     = in_valid_reg && (count_reg <= 3'd2);
    assign s_tready = !in_valid_reg || fire;
    assign pop      = m_tvalid && m_tready;

    assign head     = queue_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tuser  = head.res.event_res;
    assign m_tdata  = {7'b0000000, head.res.byte_position, head.res.byte_out,
                       head.res.frame_length, head.res.table_index, head.res.frame_id};
    assign m_tlast  = head.last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg     <= '0;
            parity_enable_reg   <= 1'b1;
            checksum_enable_reg <= 1'b1;
            for (int i = 0; i < int'(TABLE_ENTRIES); i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsfh_pkg::CFG_ENTRY_COUNT:     entry_count_reg     <= cfg_data[3:0];
                lsfh_pkg::CFG_FRAME_TABLE:
                begin
                    for (int i = 0; i < int'(TABLE_ENTRIES); i++)
                    begin
                        table_reg[i] <= cfg_data[i*lsfh_pkg::ENTRY_W +: lsfh_pkg::ENTRY_W];
                    end
                end
                lsfh_pkg::CFG_PARITY_ENABLE:   parity_enable_reg   <= cfg_data[0];
                lsfh_pkg::CFG_CHECKSUM_ENABLE: checksum_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: hold until decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Decode helpers
    assign id_in       = in_byte_reg[7:2];
    assign parity_calc = {in_byte_reg[7] ^ in_byte_reg[6] ^ in_byte_reg[5] ^ in_byte_reg[3],
                          ~(in_byte_reg[6] ^ in_byte_reg[4] ^ in_byte_reg[3] ^ in_byte_reg[2])};
    assign len_sel     = (id_in[1:0] == 2'd3) ? 4'd8 : ((id_in[1:0] == 2'd2) ? 4'd4 : 4'd2);
    assign sum_wide    = {1'b0, checksum_sum_reg} + {1'b0, in_byte_reg};
    // Wrap the carry back into bit 0
    assign sum_new     = sum_wide[7:0] + {7'b0, sum_wide[8]};
    assign count_inc   = byte_count_reg + 4'd1;

    // Parallel table compare; scan down so the lowest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        hit_rx  = 1'b0;
        for (int i = int'(TABLE_ENTRIES) - 1; i >= 0; i--)
        begin
            if ((4'(i) < entry_count_reg) && (table_reg[i][5:0] == id_in))
            begin
                hit     = 1'b1;
                hit_idx = 3'(i);
                hit_rx  = table_reg[i][6];
            end
        end
    end

    // Single-pass step
    always_comb
    begin
        phase_next           = phase_reg;
        current_id_next      = current_id_reg;
        matched_index_next   = matched_index_reg;
        expected_length_next = expected_length_reg;
        byte_count_next      = byte_count_reg;
        checksum_sum_next    = checksum_sum_reg;
        n_res                = 2'd0;
        res0                 = '0;
        res1                 = '0;
        res0.frame_id        = current_id_reg;
        res0.table_index     = matched_index_reg;
        res0.frame_length    = expected_length_reg;
        res1.frame_id        = current_id_reg;
        res1.table_index     = matched_index_reg;
        res1.frame_length    = expected_length_reg;

        unique case (in_cmd_reg)
            lsfh_pkg::CMD_BREAK:
            begin
                phase_next = PH_SYNC;
            end
            lsfh_pkg::CMD_RX_BYTE:
            begin
                unique case (phase_reg)
                    PH_SYNC:
                    begin
                        if (in_byte_reg == lsfh_pkg::SYNC_BYTE)
                        begin
                            phase_next = PH_IDENT;
                        end
                        else
                        begin
                            n_res     = 2'd1;
                            res0      = '0;
                            res0.event_res = lsfh_pkg::EV_SYNC_ERROR;
                            res0.byte_out  = in_byte_reg;
                            phase_next     = PH_IDLE;
                        end
                    end
                    PH_IDENT:
                    begin
                        phase_next = PH_IDLE;
                        n_res      = 2'd1;
                        priority if (parity_enable_reg && (in_byte_reg[1:0] != parity_calc))
                        begin
                            res0           = '0;
                            res0.event_res = lsfh_pkg::EV_PARITY_ERROR;
                            res0.frame_id  = id_in;
                            res0.byte_out  = in_byte_reg;
                        end
                        else if (!hit)
                        begin
                            res0           = '0;
                            res0.event_res = lsfh_pkg::EV_UNKNOWN_ID;
                            res0.frame_id  = id_in;
                            res0.byte_out  = in_byte_reg;
                        end
                        else
                        begin
                            current_id_next      = id_in;
                            matched_index_next   = hit_idx;
                            expected_length_next = len_sel;
                            byte_count_next      = '0;
                            checksum_sum_next    = '0;
                            res0                 = '0;
                            res0.frame_id        = id_in;
                            res0.table_index     = hit_idx;
                            res0.frame_length    = len_sel;
                            res0.event_res       = hit_rx ? lsfh_pkg::EV_RECEIVE_START
                                                          : lsfh_pkg::EV_RESPOND_REQ;
                            phase_next           = hit_rx ? PH_RXDATA : PH_TXDATA;
                        end
                    end
                    PH_RXDATA:
                    begin
                        n_res              = 2'd1;
                        res0.event_res     = lsfh_pkg::EV_DATA_BYTE;
                        res0.byte_out      = in_byte_reg;
                        res0.byte_position = byte_count_reg;
                        checksum_sum_next  = sum_new;
                        byte_count_next    = count_inc;
                        if (count_inc >= expected_length_reg)
                        begin
                            if (checksum_enable_reg)
                            begin
                                phase_next = PH_RXCK;
                            end
                            else
                            begin
                                n_res              = 2'd2;
                                res1.event_res     = lsfh_pkg::EV_FRAME_OK;
                                res1.byte_position = expected_length_reg;
                                phase_next         = PH_IDLE;
                            end
                        end
                    end
                    PH_RXCK:
                    begin
                        n_res              = 2'd1;
                        res0.event_res     = (~checksum_sum_reg == in_byte_reg)
                                             ? lsfh_pkg::EV_FRAME_OK
                                             : lsfh_pkg::EV_CHECKSUM_ERR;
                        res0.byte_out      = in_byte_reg;
                        res0.byte_position = expected_length_reg;
                        phase_next         = PH_IDLE;
                    end
                    default: ;
                endcase
            end
            lsfh_pkg::CMD_TX_BYTE:
            begin
                if (phase_reg == PH_TXDATA)
                begin
                    n_res              = 2'd2;
                    res0.event_res     = lsfh_pkg::EV_TX_BYTE;
                    res0.byte_out      = in_byte_reg;
                    res0.byte_position = byte_count_reg;
                    checksum_sum_next  = sum_new;
                    byte_count_next    = count_inc;
                    if (count_inc >= expected_length_reg)
                    begin
                        res1.byte_position = expected_length_reg;
                        if (checksum_enable_reg)
                        begin
                            res1.event_res = lsfh_pkg::EV_TX_CHECKSUM;
                            res1.byte_out  = ~sum_new;
                        end
                        else
                        begin
                            res1.event_res = lsfh_pkg::EV_FRAME_OK;
                        end
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res1.event_res     = lsfh_pkg::EV_RESPOND_REQ;
                        res1.byte_position = count_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            current_id_reg      <= '0;
            matched_index_reg   <= '0;
            expected_length_reg <= '0;
            byte_count_reg      <= '0;
            checksum_sum_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            current_id_reg      <= current_id_next;
            matched_index_reg   <= matched_index_next;
            expected_length_reg <= expected_length_next;
            byte_count_reg      <= byte_count_next;
            checksum_sum_reg    <= checksum_sum_next;
        end
    end

    // Output queue: push up to two, pop one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (n_res != 2'd0))
        begin
            queue_mem[wr_ptr_reg] <= '{last: (n_res == 2'd1), res: res0};
        end
        if (fire && (n_res == 2'd2))
        begin
            queue_mem[2'(wr_ptr_reg + 2'd1)] <= '{last: 1'b1, res: res1};
        end
    end

    `LSFH_ASSERT_ALWAYS(a_queue_bound, count_reg <= 3'(QUEUE_DEPTH))
    `LSFH_ASSERT_ALWAYS(a_count_in_frame,
        !((phase_reg == PH_RXDATA) || (phase_reg == PH_TXDATA)) ||
        (byte_count_reg < expected_length_reg))
    `LSFH_ASSERT_NEXT(a_hold_input, in_valid_reg && !fire,
        in_valid_reg && $stable(in_cmd_reg) && $stable(in_byte_reg))
    `LSFH_ASSERT_NEXT(a_ident_exit,
        fire && (phase_reg == PH_IDENT) && (in_cmd_reg == lsfh_pkg::CMD_RX_BYTE),
        (phase_reg == PH_IDLE) || (phase_reg == PH_RXDATA) || (phase_reg == PH_TXDATA))

endmodule

`default_nettype wire

>>> tb/sv/lin_frame_check_pkg.sv
// Frame state predictor and result scoreboard for the LIN slave frame handler testbench.
`timescale 1ns / 1ps

package lin_frame_check_pkg;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_SYNC,
        ST_WAIT_IDENT,
        ST_RX_DATA,
        ST_RX_CHECKSUM,
        ST_TX_DATA
    } link_state_t;

    // Identifier parity for a six-bit frame ID: bit 1 is id[5]^id[4]^id[3]^id[1], bit 0 is ~(id[4]^id[2]^id[1]^id[0]).
    function automatic logic [1:0] ident_parity(logic [5:0] id);
        return {id[5] ^ id[4] ^ id[3] ^ id[1], ~(id[4] ^ id[2] ^ id[1] ^ id[0])};
    endfunction

    class lin_frame_scoreboard;
        logic [3:0]   entry_count;
        logic [55:0]  frame_table;
        logic         parity_en;
        logic         checksum_en;
        link_state_t  state;
        logic [5:0]   cur_id;
        logic [2:0]   cur_index;
        logic [3:0]   frame_len;
        logic [3:0]   byte_cnt;
        logic [7:0]   running_sum;
        lsfh_pkg::queue_entry_t pending[$];
        int           mismatches;
        int           checked;
        int           event_seen[10];

        function new();
            entry_count = '0;
            frame_table = '0;
            parity_en   = 1'b1;
            checksum_en = 1'b1;
            state       = ST_IDLE;
            cur_id      = '0;
            cur_index   = '0;
            frame_len   = '0;
            byte_cnt    = '0;
            running_sum = '0;
            mismatches  = 0;
            checked     = 0;
            foreach (event_seen[i])
                event_seen[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [55:0] value);
            case (idx)
                lsfh_pkg::CFG_ENTRY_COUNT:     entry_count = value[3:0];
                lsfh_pkg::CFG_FRAME_TABLE:     frame_table = value;
                lsfh_pkg::CFG_PARITY_ENABLE:   parity_en   = value[0];
                lsfh_pkg::CFG_CHECKSUM_ENABLE: checksum_en = value[0];
                default: ;
            endcase
        endfunction

        // Classic LIN sum: add with the carry folded back in.
        function logic [7:0] sum_wrap(logic [7:0] s, logic [7:0] b);
            logic [8:0] t;
            t = {1'b0, s} + {1'b0, b};
            if (t[8])
                t = t - 9'd255;
            return t[7:0];
        endfunction

        function lsfh_pkg::queue_entry_t make_event(lsfh_pkg::event_t ev, logic [7:0] b,
                                                    logic [3:0] pos);
            lsfh_pkg::queue_entry_t e;
            e.last              = 1'b0;
            e.res.event_res     = ev;
            e.res.frame_id      = cur_id;
            e.res.table_index   = cur_index;
            e.res.frame_length  = frame_len;
            e.res.byte_out      = b;
            e.res.byte_position = pos;
            return e;
        endfunction

        function lsfh_pkg::queue_entry_t make_reject(lsfh_pkg::event_t ev, logic [5:0] id,
                                                     logic [7:0] b);
            lsfh_pkg::queue_entry_t e;
            e.last              = 1'b0;
            e.res.event_res     = ev;
            e.res.frame_id      = id;
            e.res.table_index   = '0;
            e.res.frame_length  = '0;
            e.res.byte_out      = b;
            e.res.byte_position = '0;
            return e;
        endfunction

        // Advance the frame state for one accepted request and queue its results.
        // Returns 1 for a break and for any other request that produced results or moved the frame state.
        function int note_request(logic [1:0] cmd, logic [7:0] b);
            lsfh_pkg::queue_entry_t outs[2];
            int           n;
            int           i;
            int           active;
            link_state_t  prev;
            logic [6:0]   entry;
            logic [5:0]   id;
            logic [7:0]   want;
            logic         found;
            logic         rx;
            n     = 0;
            prev  = state;
            found = 1'b0;
            rx    = 1'b0;
            id    = b[7:2];
            if (cmd == lsfh_pkg::CMD_BREAK)
            begin
                state = ST_WAIT_SYNC;
                return 1;
            end
            if (cmd == lsfh_pkg::CMD_RX_BYTE)
            begin
                case (state)
                    ST_WAIT_SYNC:
                    begin
                        if (b == lsfh_pkg::SYNC_BYTE)
                            state = ST_WAIT_IDENT;
                        else
                        begin
                            outs[n] = make_reject(lsfh_pkg::EV_SYNC_ERROR, 6'd0, b);
                            n++;
                            state = ST_IDLE;
                        end
                    end
                    ST_WAIT_IDENT:
                    begin
                        state = ST_IDLE;
                        if (parity_en && b[1:0] != ident_parity(id))
                        begin
                            outs[n] = make_reject(lsfh_pkg::EV_PARITY_ERROR, id, b);
                            n++;
                        end
                        else
                        begin
                            active = (entry_count > 4'd8) ? 8 : int'(entry_count);
                            // lowest matching index wins
                            for (i = 0; i < 8; i++)
                            begin
                                entry = frame_table[7*i +: 7];
                                if (!found && i < active && entry[5:0] == id)
                                begin
                                    found     = 1'b1;
                                    cur_index = 3'(i);
                                    rx        = entry[6];
                                end
                            end
                            if (!found)
                            begin
                                outs[n] = make_reject(lsfh_pkg::EV_UNKNOWN_ID, id, b);
                                n++;
                            end
                            else
                            begin
                                cur_id = id;
                                case (id[1:0])
                                    2'd3:    frame_len = 4'd8;
                                    2'd2:    frame_len = 4'd4;
                                    default: frame_len = 4'd2;
                                endcase
                                byte_cnt    = '0;
                                running_sum = '0;
                                if (rx)
                                begin
                                    outs[n] = make_event(lsfh_pkg::EV_RECEIVE_START, 8'd0, 4'd0);
                                    state = ST_RX_DATA;
                                end
                                else
                                begin
                                    outs[n] = make_event(lsfh_pkg::EV_RESPOND_REQ, 8'd0, 4'd0);
                                    state = ST_TX_DATA;
                                end
                                n++;
                            end
                        end
                    end
                    ST_RX_DATA:
                    begin
                        outs[n] = make_event(lsfh_pkg::EV_DATA_BYTE, b, byte_cnt);
                        n++;
                        running_sum = sum_wrap(running_sum, b);
                        byte_cnt    = byte_cnt + 4'd1;
                        if (byte_cnt >= frame_len)
                        begin
                            if (checksum_en)
                                state = ST_RX_CHECKSUM;
                            else
                            begin
                                outs[n] = make_event(lsfh_pkg::EV_FRAME_OK, 8'd0, frame_len);
                                n++;
                                state = ST_IDLE;
                            end
                        end
                    end
                    ST_RX_CHECKSUM:
                    begin
                        want = ~running_sum;
                        if (want == b)
                            outs[n] = make_event(lsfh_pkg::EV_FRAME_OK, b, frame_len);
                        else
                            outs[n] = make_event(lsfh_pkg::EV_CHECKSUM_ERR, b, frame_len);
                        n++;
                        state = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            else if (cmd == lsfh_pkg::CMD_TX_BYTE && state == ST_TX_DATA)
            begin
                outs[n] = make_event(lsfh_pkg::EV_TX_BYTE, b, byte_cnt);
                n++;
                running_sum = sum_wrap(running_sum, b);
                byte_cnt    = byte_cnt + 4'd1;
                if (byte_cnt >= frame_len)
                begin
                    if (checksum_en)
                        outs[n] = make_event(lsfh_pkg::EV_TX_CHECKSUM, ~running_sum, frame_len);
                    else
                        outs[n] = make_event(lsfh_pkg::EV_FRAME_OK, 8'd0, frame_len);
                    state = ST_IDLE;
                end
                else
                    outs[n] = make_event(lsfh_pkg::EV_RESPOND_REQ, 8'd0, byte_cnt);
                n++;
            end
            if (n > 0)
                outs[n-1].last = 1'b1;
            for (i = 0; i < n; i++)
                pending.push_back(outs[i]);
            return (n > 0 || state != prev) ? 1 : 0;
        endfunction

        function void check_result(logic [3:0] kind, logic [31:0] data, logic tl);
            lsfh_pkg::queue_entry_t want;
            lsfh_pkg::result_t      got;
            got = lsfh_pkg::result_t'({data[24:0], kind});
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: tuser %h tdata %h tlast %b", kind, data, tl);
                return;
            end
            want = pending.pop_front();
            checked++;
            event_seen[int'(want.res.event_res)]++;
            if (got.event_res !== want.res.event_res || got.frame_id !== want.res.frame_id
                || got.table_index !== want.res.table_index
                || got.frame_length !== want.res.frame_length
                || got.byte_out !== want.res.byte_out
                || got.byte_position !== want.res.byte_position || tl !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("expected: ev %0d id %h idx %0d len %0d byte %h pos %0d last %b",
                             want.res.event_res, want.res.frame_id, want.res.table_index,
                             want.res.frame_length, want.res.byte_out,
                             want.res.byte_position, want.last);
                    $display("actual:   ev %0d id %h idx %0d len %0d byte %h pos %0d last %b",
                             got.event_res, got.frame_id, got.table_index, got.frame_length,
                             got.byte_out, got.byte_position, tl);
                end
            end
        endfunction
    endclass

endpackage

>>> tb/sv/lin_slave_frame_handler_core_test.sv
// Top-level testbench: drives frames through the LIN slave frame handler and checks every result.
`timescale 1ns / 1ps

module lin_slave_frame_handler_core_test;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          SEGMENTS      = 6;
    // entries 0..7: rx 10, tx 21, rx 12, rx 3F, tx 0B, tx 10 (shadowed), tx 06, rx 2A
    localparam logic [55:0] DIRECTED_TABLE =
        {7'h6A, 7'h06, 7'h10, 7'h0B, 7'h7F, 7'h52, 7'h21, 7'h50};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [55:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] byte_in
    logic [1:0]  s_tuser = '0;     // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [5:0] frame_id, [8:6] table_index, [12:9] frame_length,
                                   // [20:13] byte_out, [24:21] byte_position
    logic [3:0]  m_tuser;          // [3:0] event_res
    logic        m_tlast;

    lin_frame_check_pkg::lin_frame_scoreboard sb;
    int src_idle_pct = 33;
    int sink_idle_pct = 64;
    int requests_sent = 0;
    int effective_items = 0;
    int cycle_count = 0;

    lin_slave_frame_handler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lin_slave_frame_handler_core_test NOT OK");
        $finish;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= sink_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);

    function automatic logic [7:0] ident_byte(logic [5:0] id);
        return {id, lin_frame_check_pkg::ident_parity(id)};
    endfunction

    function automatic logic [7:0] data_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [55:0] random_table();
        logic [55:0] t;
        int          dup;
        t = {24'($urandom), 32'($urandom)};
        // plant a duplicate of entry 0 with the other direction
        if ($urandom_range(1))
        begin
            dup = $urandom_range(1, 7);
            t[7*dup +: 6] = t[5:0];
            t[7*dup + 6]  = ~t[6];
        end
        return t;
    endfunction

    task automatic send_request(logic [1:0] cmd, logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        effective_items += sb.note_request(cmd, b);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [55:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic load_config(logic [3:0] cnt, logic [55:0] tbl, logic par, logic ck);
        write_reg(lsfh_pkg::CFG_ENTRY_COUNT, 56'(cnt));
        write_reg(lsfh_pkg::CFG_FRAME_TABLE, tbl);
        write_reg(lsfh_pkg::CFG_PARITY_ENABLE, 56'(par));
        write_reg(lsfh_pkg::CFG_CHECKSUM_ENABLE, 56'(ck));
    endtask

    task automatic directed_frames();
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);  // idle: dropped
        send_request(lsfh_pkg::CMD_TX_BYTE, 8'hAA);        // no transmit frame: dropped
        send_request(CMD_UNUSED, 8'hFF);
        send_request(lsfh_pkg::CMD_BREAK, 8'h00);
        send_request(lsfh_pkg::CMD_RX_BYTE, 8'h00);        // bad sync
        send_request(lsfh_pkg::CMD_BREAK, 8'hFF);
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
        send_request(lsfh_pkg::CMD_RX_BYTE, ident_byte(6'h10) ^ 8'h01);
        send_request(lsfh_pkg::CMD_BREAK, 8'h00);
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
        send_request(lsfh_pkg::CMD_RX_BYTE, ident_byte(6'h33));  // not in table
        send_request(lsfh_pkg::CMD_BREAK, 8'h00);
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
        send_request(lsfh_pkg::CMD_RX_BYTE, ident_byte(6'h10));
        send_request(lsfh_pkg::CMD_RX_BYTE, 8'hFF);
        send_request(lsfh_pkg::CMD_RX_BYTE, 8'hFF);
        send_request(lsfh_pkg::CMD_RX_BYTE, ~sb.running_sum);
        send_request(lsfh_pkg::CMD_BREAK, 8'h00);
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
        send_request(lsfh_pkg::CMD_RX_BYTE, ident_byte(6'h21));
        send_request(lsfh_pkg::CMD_TX_BYTE, 8'h00);
        send_request(lsfh_pkg::CMD_TX_BYTE, 8'hFF);
        send_request(lsfh_pkg::CMD_BREAK, 8'h00);
        send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
        send_request(lsfh_pkg::CMD_RX_BYTE, ident_byte(6'h3F));  // left open for the next phase
    endtask

    task automatic random_frame();
        int         roll;
        int         active;
        int         k;
        logic [5:0] id;
        logic [7:0] ident;
        // hold off now and then until the block has answered everything
        if ($urandom_range(39) == 0)
            wait_results_drained();
        roll = $urandom_range(99);
        if (roll < 72)
        begin
            send_request(lsfh_pkg::CMD_BREAK, 8'($urandom));
            send_request(lsfh_pkg::CMD_RX_BYTE,
                         ($urandom_range(19) == 0) ? 8'($urandom) : lsfh_pkg::SYNC_BYTE);
            if (sb.state != lin_frame_check_pkg::ST_WAIT_IDENT)
                return;
            active = (sb.entry_count > 4'd8) ? 8 : int'(sb.entry_count);
            if (active > 0 && $urandom_range(9) < 8)
            begin
                k  = $urandom_range(active - 1);
                id = sb.frame_table[7*k +: 6];
            end
            else
                id = 6'($urandom);
            ident = ident_byte(id);
            if ($urandom_range(15) == 0)
                ident[1:0] = ident[1:0] ^ 2'($urandom_range(1, 3));
            send_request(lsfh_pkg::CMD_RX_BYTE, ident);
            while (sb.state == lin_frame_check_pkg::ST_RX_DATA)
            begin
                if ($urandom_range(29) == 0)
                    send_request(lsfh_pkg::CMD_TX_BYTE, 8'($urandom));
                else if ($urandom_range(59) == 0)
                    send_request(lsfh_pkg::CMD_BREAK, 8'($urandom));
                else
                    send_request(lsfh_pkg::CMD_RX_BYTE, data_byte());
            end
            if (sb.state == lin_frame_check_pkg::ST_RX_CHECKSUM)
                send_request(lsfh_pkg::CMD_RX_BYTE,
                             ($urandom_range(7) == 0) ? 8'($urandom) : ~sb.running_sum);
            while (sb.state == lin_frame_check_pkg::ST_TX_DATA)
            begin
                if ($urandom_range(29) == 0)
                    send_request(lsfh_pkg::CMD_RX_BYTE, 8'($urandom));
                else if ($urandom_range(79) == 0)
                    send_request(lsfh_pkg::CMD_BREAK, 8'($urandom));
                else
                    send_request(lsfh_pkg::CMD_TX_BYTE, data_byte());
            end
        end
        else if (roll < 88)
        begin
            repeat ($urandom_range(1, 4))
                send_request(2'($urandom), 8'($urandom));
        end
        else
        begin
            send_request(lsfh_pkg::CMD_BREAK, 8'($urandom));
            if ($urandom_range(1))
                send_request(lsfh_pkg::CMD_RX_BYTE, 8'($urandom));
            else
            begin
                send_request(lsfh_pkg::CMD_RX_BYTE, lsfh_pkg::SYNC_BYTE);
                send_request(lsfh_pkg::CMD_RX_BYTE, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        int target;
        int seg;
        sb = new();
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_config(4'd8, DIRECTED_TABLE, 1'b1, 1'b1);
        directed_frames();

        target = effective_items;
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct  = 33;
                    sink_idle_pct = 64;
                end
                1:
                begin
                    src_idle_pct  = 64;
                    sink_idle_pct = 33;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            wait_results_drained();
            repeat (SETTLE_CYCLES)
                @(negedge clk);
            case (seg)
                0:
                begin
                    load_config(4'd8, random_table(), 1'b1, 1'b1);
                    target += 200;
                end
                1:
                begin
                    load_config(4'($urandom_range(1, 7)), random_table(), 1'b0, 1'b0);
                    target += 180;
                end
                2:
                begin
                    load_config(4'd8, '1, 1'b1, 1'b0);
                    target += 150;
                end
                3:
                begin
                    load_config(4'd0, '0, 1'b0, 1'b1);
                    target += 80;
                end
                4:
                begin
                    load_config(4'($urandom_range(1, 8)), random_table(), 1'b1, 1'b0);
                    target += 250;
                end
                default:
                begin
                    load_config(4'd8, random_table(), 1'b0, 1'b1);
                    target += 265;
                end
            endcase
            while (effective_items < target)
                random_frame();
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        $display("%0d requests (%0d effective) over %0d table setups, %0d results checked",
                 requests_sent, effective_items, SEGMENTS + 1, sb.checked);
        $display("frames ok %0d, checksum errors %0d, tx checksums %0d, rejects %0d",
                 sb.event_seen[lsfh_pkg::EV_FRAME_OK], sb.event_seen[lsfh_pkg::EV_CHECKSUM_ERR],
                 sb.event_seen[lsfh_pkg::EV_TX_CHECKSUM],
                 sb.event_seen[lsfh_pkg::EV_SYNC_ERROR] + sb.event_seen[lsfh_pkg::EV_PARITY_ERROR]
                 + sb.event_seen[lsfh_pkg::EV_UNKNOWN_ID]);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("lin_slave_frame_handler_core_test OK");
        else
            $display("lin_slave_frame_handler_core_test NOT OK");
        $finish;
    end

endmodule
